@@ sv/aga_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aga_pkg
// Shared types, constants and the divide-by-255 helper for the global-alpha
// ARGB blend pipeline.
// ----------------------------------------------------------------------------
package aga_pkg;

    localparam int unsigned PIX_W  = 32;
    localparam int unsigned CHAN_W = 8;
    localparam int unsigned NCHAN  = PIX_W / CHAN_W;
    localparam int unsigned PROD_W = 2 * CHAN_W;

    localparam logic [CHAN_W-1:0] ALPHA_MAX  = 8'hFF;
    localparam logic [CHAN_W-1:0] ALPHA_ZERO = 8'h00;

    // Control that travels with each pixel down the pipeline
    typedef struct packed {
        logic valid;
        logic tail;
        logic ga_zero;
    } t_ctl;

    // (x + (x >> 8) + 1) >> 8; the sum stays within 16 bits for x <= 65279
    function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
        logic [PROD_W:0] acc;
        acc = {1'b0, x} + {{(CHAN_W + 1){1'b0}}, x[PROD_W-1:CHAN_W]}
              + {{PROD_W{1'b0}}, 1'b1};
        return acc[PROD_W-1:CHAN_W];
    endfunction

endpackage

@@ sv/aga_alpha_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aga_alpha_stage
// Effective alpha: src alpha times global alpha in the first stage, scaled
// down by 255 in the second. Pixels and control ride along.
// ----------------------------------------------------------------------------
module aga_alpha_stage (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [aga_pkg::PIX_W-1:0]       i_src_pixel,
    input  logic [aga_pkg::PIX_W-1:0]       i_dst_pixel,
    input  logic                            i_tail_rule,
    input  logic [aga_pkg::CHAN_W-1:0]      i_global_alpha,
    output aga_pkg::t_ctl                   o_ctl,
    output logic [aga_pkg::CHAN_W-1:0]      o_ea,
    output logic [aga_pkg::PIX_W-1:0]       o_src_pixel,
    output logic [aga_pkg::PIX_W-1:0]       o_dst_pixel
);

    aga_pkg::t_ctl                    r_ctl1, r_ctl2;
    logic [aga_pkg::PROD_W-1:0]       r_prod;
    logic [aga_pkg::PIX_W-1:0]        r_src1, r_dst1, r_src2, r_dst2;
    logic [aga_pkg::CHAN_W-1:0]       r_ea;

    aga_pkg::t_ctl                    n_ctl1;
    logic [aga_pkg::PROD_W-1:0]       n_prod;

    always_comb begin
        n_ctl1.valid   = i_valid;
        n_ctl1.tail    = i_tail_rule;
        n_ctl1.ga_zero = (i_global_alpha == aga_pkg::ALPHA_ZERO);
        n_prod = {{aga_pkg::CHAN_W{1'b0}}, i_src_pixel[aga_pkg::PIX_W-1 -: aga_pkg::CHAN_W]}
               * {{aga_pkg::CHAN_W{1'b0}}, i_global_alpha};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
        end else begin
            r_ctl1 <= n_ctl1;
            r_ctl2 <= r_ctl1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_src1 <= i_src_pixel;
        r_dst1 <= i_dst_pixel;
        r_ea   <= aga_pkg::div255(r_prod);
        r_src2 <= r_src1;
        r_dst2 <= r_dst1;
    end

    assign o_ctl       = r_ctl2;
    assign o_ea        = r_ea;
    assign o_src_pixel = r_src2;
    assign o_dst_pixel = r_dst2;

endmodule

@@ sv/aga_mix_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aga_mix_stage
// Per-channel weighted sum s*ea + d*(255-ea) in one stage, then the divide by
// 255 and the rule select into the output register.
// ----------------------------------------------------------------------------
module aga_mix_stage (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  aga_pkg::t_ctl                   i_ctl,
    input  logic [aga_pkg::CHAN_W-1:0]      i_ea,
    input  logic [aga_pkg::PIX_W-1:0]       i_src_pixel,
    input  logic [aga_pkg::PIX_W-1:0]       i_dst_pixel,
    output logic                            o_valid,
    output logic [aga_pkg::PIX_W-1:0]       o_blended_pixel
);

    aga_pkg::t_ctl                    r_ctl3;
    logic [aga_pkg::PROD_W-1:0]       r_sum [aga_pkg::NCHAN];
    logic [aga_pkg::CHAN_W-1:0]       r_ea3;
    logic [aga_pkg::PIX_W-1:0]        r_src3, r_dst3;
    logic                             r_valid4;
    logic [aga_pkg::PIX_W-1:0]        r_pix4;

    logic [aga_pkg::PROD_W-1:0]       n_sum [aga_pkg::NCHAN];
    logic [aga_pkg::CHAN_W-1:0]       inv_ea;
    logic [aga_pkg::PIX_W-1:0]        blend;
    logic [aga_pkg::PIX_W-1:0]        n_pix4;

    assign inv_ea = aga_pkg::ALPHA_MAX - i_ea;

    // Sum never exceeds 255*255, so 16 bits hold it
    always_comb begin
        for (int c = 0; c < aga_pkg::NCHAN; c++) begin
            n_sum[c] = {{aga_pkg::CHAN_W{1'b0}}, i_src_pixel[c*aga_pkg::CHAN_W +: aga_pkg::CHAN_W]}
                     * {{aga_pkg::CHAN_W{1'b0}}, i_ea}
                     + {{aga_pkg::CHAN_W{1'b0}}, i_dst_pixel[c*aga_pkg::CHAN_W +: aga_pkg::CHAN_W]}
                     * {{aga_pkg::CHAN_W{1'b0}}, inv_ea};
        end
    end

    always_comb begin
        for (int c = 0; c < aga_pkg::NCHAN; c++) begin
            blend[c*aga_pkg::CHAN_W +: aga_pkg::CHAN_W] = aga_pkg::div255(r_sum[c]);
        end
        if (r_ctl3.ga_zero) begin
            n_pix4 = r_dst3;
        end else if (r_ctl3.tail) begin
            if (r_ea3 == aga_pkg::ALPHA_ZERO) begin
                n_pix4 = r_dst3;
            end else if (r_ea3 == aga_pkg::ALPHA_MAX) begin
                n_pix4 = r_src3;
            end else begin
                // force opaque alpha, blend RGB only
                n_pix4 = {aga_pkg::ALPHA_MAX, blend[aga_pkg::PIX_W-aga_pkg::CHAN_W-1:0]};
            end
        end else begin
            n_pix4 = blend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl3   <= '0;
            r_valid4 <= 1'b0;
        end else begin
            r_ctl3   <= i_ctl;
            r_valid4 <= r_ctl3.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum  <= n_sum;
        r_ea3  <= i_ea;
        r_src3 <= i_src_pixel;
        r_dst3 <= i_dst_pixel;
        r_pix4 <= n_pix4;
    end

    assign o_valid         = r_valid4;
    assign o_blended_pixel = r_pix4;

endmodule

@@ sv/argb_global_alpha_blend.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// argb_global_alpha_blend
// Blends an ARGB8888 source pixel over a destination pixel under a global
// alpha, with a vector rule and an odd-run tail rule.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive i_src_pixel, i_dst_pixel and i_tail_rule with start high;
//   the transaction is taken at that edge when busy is low. busy never rises,
//   so one pixel enters every clock.
//   Output: o_blended_pixel is shown for one cycle with o_result_valid high,
//   after four register stages (alpha product, effective alpha, channel
//   sums, divide and select). Throughput is one pixel per clock; results
//   leave in input order.
//   Config: the global alpha is written through i_cfg_valid/o_cfg_ready with
//   data on i_cfg_global_alpha; o_cfg_ready is always high. Write it only
//   while no pixel is in flight.
//   Reset: synchronous, active low; clears the pipeline valid bits and sets
//   the global alpha to 255. No clearing pass is needed.
//   The receiver cannot stall; results are never held back.
// ----------------------------------------------------------------------------
module argb_global_alpha_blend (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [aga_pkg::PIX_W-1:0]       i_src_pixel,
    input  logic [aga_pkg::PIX_W-1:0]       i_dst_pixel,
    input  logic                            i_tail_rule,
    output logic                            o_result_valid,
    output logic [aga_pkg::PIX_W-1:0]       o_blended_pixel,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [aga_pkg::CHAN_W-1:0]      i_cfg_global_alpha
);

    logic [aga_pkg::CHAN_W-1:0]       r_global_alpha;
    logic                             accept;
    aga_pkg::t_ctl                    ctl2;
    logic [aga_pkg::CHAN_W-1:0]       ea2;
    logic [aga_pkg::PIX_W-1:0]        src2, dst2;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_global_alpha <= aga_pkg::ALPHA_MAX;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_global_alpha <= i_cfg_global_alpha;
        end
    end

    aga_alpha_stage u_alpha (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (accept),
        .i_src_pixel    (i_src_pixel),
        .i_dst_pixel    (i_dst_pixel),
        .i_tail_rule    (i_tail_rule),
        .i_global_alpha (r_global_alpha),
        .o_ctl          (ctl2),
        .o_ea           (ea2),
        .o_src_pixel    (src2),
        .o_dst_pixel    (dst2)
    );

    aga_mix_stage u_mix (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl2),
        .i_ea            (ea2),
        .i_src_pixel     (src2),
        .i_dst_pixel     (dst2),
        .o_valid         (o_result_valid),
        .o_blended_pixel (o_blended_pixel)
    );

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##4 o_result_valid)
        else $error("accepted pixel did not emerge after four cycles");

    a_zero_ga_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_global_alpha == aga_pkg::ALPHA_ZERO)
        |-> ##4 (o_blended_pixel == $past(i_dst_pixel, 4)))
        else $error("zero global alpha did not pass destination through");

    a_tail_clear_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_tail_rule
         && i_src_pixel[aga_pkg::PIX_W-1 -: aga_pkg::CHAN_W] == aga_pkg::ALPHA_ZERO)
        |-> ##4 (o_blended_pixel == $past(i_dst_pixel, 4)))
        else $error("tail rule with clear source changed destination");
`endif

endmodule
